>>> design/u16u8_pkg.sv
// Package: shared types, constants and the UTF-8 byte encoder for the transcoder.
`default_nettype none

package u16u8_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [5:0]  SurrHighTag  = 6'b110110;
  localparam logic [5:0]  SurrLowTag   = 6'b110111;
  localparam logic [20:0] ReplChar     = 21'h00FFFD;
  localparam logic [20:0] SuppBase     = 21'h010000;
  localparam logic [20:0] Max1Byte     = 21'h00007F;
  localparam logic [20:0] Max2Byte     = 21'h0007FF;
  localparam logic [20:0] Max3Byte     = 21'h00FFFF;
  localparam logic [1:0]  ReplLenM1    = 2'd2;
  localparam logic [2:0]  ReplSteps    = 3'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // One queued transaction: an optional U+FFFD prefix, then one code point.
  typedef struct packed {
    logic        prefix;
    logic [20:0] cp;
    logic [1:0]  len_m1;
    logic [2:0]  steps_m1;
    logic        fin;
  } cp_rec_t;

  function automatic logic [1:0] cp_len_m1(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= Max1Byte) begin
      r = 2'd0;
    end else if (cp <= Max2Byte) begin
      r = 2'd1;
    end else if (cp <= Max3Byte) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                          input logic [1:0] k);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (len_m1)
      2'd0: b = cp[7:0];
      2'd1: begin
        if (k == 2'd0) b = {3'b110, cp[10:6]};
      end
      2'd2: begin
        case (k)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/utf16_to_utf8_transcoder_top.sv
// UTF-16 to UTF-8 transcoder, top level.
// Input channel: in_valid_i / in_stall_o carry one UTF-16 code unit per
// transaction plus a flag on the final unit of the string.
// Output channel: out_valid_o / out_stall_i carry one UTF-8 byte per
// transaction, with run_last on the last byte caused by a code unit and
// string_end on the last byte of the string.
// The first byte of a unit passes through the record queue and then the output
// register before it reaches the output when the block is otherwise empty.
// Throughput: one byte per cycle out of the single output register while
// out_stall_i is low; a unit causes 0 bytes for a held high surrogate, 1 to 4
// for a code point, up to 6 when a broken pair adds U+FFFD. Units keep being
// accepted while bytes drain, until the record queue (QueueDepth entries) is
// full.
// Reset clears the queue, the output valid and any held high surrogate.
// While out_stall_i is high the output byte holds; the queue keeps filling
// and in_stall_o rises once it is full.
`default_nettype none

module utf16_to_utf8_transcoder_top #(
  parameter int unsigned QueueDepth = u16u8_pkg::QueueDepthDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire u16u8_pkg::in_item_t in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output u16u8_pkg::out_item_t     out_data_o
);

  logic q_wr, q_full, q_rd, q_empty, pending;
  u16u8_pkg::cp_rec_t q_wdata, q_rdata;

  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .q_wdata_o  (q_wdata),
    .pending_o  (pending)
  );

  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_rdata),
    .empty_i     (q_empty),
    .pop_o       (q_rd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_wr && q_full)) else $error("record written into a full queue");

  a_final_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.final_unit) |=> !pending)
    else $error("surrogate held past end of string");

  a_end_implies_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.string_end) |-> out_data_o.run_last)
    else $error("string_end without run_last");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_rd && q_empty)) else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> design/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and queues code point records.
`default_nettype none

module u16u8_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire u16u8_pkg::in_item_t in_data_i,
  input  wire                      q_full_i,
  output logic                     q_wr_o,
  output u16u8_pkg::cp_rec_t       q_wdata_o,
  output logic                     pending_o
);

  logic       pending_q, pending_d;
  logic [9:0] held_q, held_d;
  logic       accept, is_high, is_low, pair, hold;
  logic [20:0] pair_cp, body_cp;
  u16u8_pkg::cp_rec_t rec;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_high = in_data_i.code_unit[15:10] == u16u8_pkg::SurrHighTag;
  assign is_low  = in_data_i.code_unit[15:10] == u16u8_pkg::SurrLowTag;
  assign pair    = pending_q && is_low;
  assign hold    = !pair && is_high && !in_data_i.final_unit;

  assign pair_cp = u16u8_pkg::SuppBase + {1'b0, held_q, in_data_i.code_unit[9:0]};
  assign body_cp = (is_high || is_low) ? u16u8_pkg::ReplChar : {5'd0, in_data_i.code_unit};

  always_comb begin
    rec.fin = in_data_i.final_unit;
    if (hold) begin
      rec.prefix = 1'b0;
      rec.cp     = u16u8_pkg::ReplChar;
    end else begin
      rec.prefix = pending_q && !pair;
      rec.cp     = pair ? pair_cp : body_cp;
    end
    rec.len_m1   = u16u8_pkg::cp_len_m1(rec.cp);
    rec.steps_m1 = {1'b0, rec.len_m1} + (rec.prefix ? u16u8_pkg::ReplSteps : 3'd0);
  end

  assign q_wr_o    = accept && (!hold || pending_q);
  assign q_wdata_o = rec;
  assign pending_o = pending_q;

  always_comb begin
    pending_d = pending_q;
    held_d    = held_q;
    if (accept) begin
      pending_d = hold;
      held_d    = hold ? in_data_i.code_unit[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= 10'd0;
    end else begin
      pending_q <= pending_d;
      held_q    <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> design/u16u8_queue.sv
// Small record queue between the front end and the byte serializer.
`default_nettype none

module u16u8_queue #(
  parameter int unsigned Depth = u16u8_pkg::QueueDepthDef
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     wr_i,
  input  wire u16u8_pkg::cp_rec_t wdata_i,
  output logic                    full_o,
  input  wire                     rd_i,
  output u16u8_pkg::cp_rec_t      rdata_o,
  output logic                    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u16u8_pkg::cp_rec_t entries_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = entries_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    if (do_rd) rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) entries_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> design/u16u8_back.sv
// Back end: serializes queued records into UTF-8 bytes through an output register.
`default_nettype none

module u16u8_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire u16u8_pkg::cp_rec_t head_i,
  input  wire                     empty_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output u16u8_pkg::out_item_t    out_data_o
);

  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  u16u8_pkg::out_item_t out_q, out_d;
  logic       load, last, in_prefix;
  logic [2:0] k;
  logic [7:0] byte_val;

  assign load      = !empty_i && (!out_valid_q || !out_stall_i);
  assign last      = step_q == head_i.steps_m1;
  assign in_prefix = head_i.prefix && (step_q < u16u8_pkg::ReplSteps);
  assign k         = step_q - (head_i.prefix ? u16u8_pkg::ReplSteps : 3'd0);
  assign byte_val  = in_prefix
                   ? u16u8_pkg::enc_byte(u16u8_pkg::ReplChar, u16u8_pkg::ReplLenM1, step_q[1:0])
                   : u16u8_pkg::enc_byte(head_i.cp, head_i.len_m1, k[1:0]);
  assign pop_o     = load && last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    out_d       = out_q;
    if (load) begin
      step_d           = last ? 3'd0 : step_q + 3'd1;
      out_valid_d      = 1'b1;
      out_d.utf8_byte  = byte_val;
      out_d.run_last   = last;
      out_d.string_end = last && head_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sim/tb_utf16_to_utf8_transcoder_top.sv
// Testbench for the UTF-16 to UTF-8 transcoder: directed and random strings, byte-level checking.
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder_top;

  class utf8_scoreboard;
    bit                   high_held;
    logic [9:0]           held_bits;
    u16u8_pkg::out_item_t expected_bytes[$];
    int unsigned          errors;

    function new();
      high_held = 1'b0;
      held_bits = '0;
      errors    = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      u16u8_pkg::out_item_t item;
      item.utf8_byte  = b;
      item.run_last   = 1'b0;
      item.string_end = 1'b0;
      expected_bytes.insert(expected_bytes.size(), item);
    endfunction

    function void encode_cp(logic [20:0] cp);
      if (cp < 21'h80) begin
        push_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end else begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endfunction

    function void note_unit(u16u8_pkg::in_item_t unit);
      int unsigned          start_count;
      logic                 is_high;
      logic                 is_low;
      bit                   paired;
      u16u8_pkg::out_item_t tail;
      start_count = expected_bytes.size();
      is_high     = unit.code_unit[15:10] == 6'b110110;
      is_low      = unit.code_unit[15:10] == 6'b110111;
      paired      = 1'b0;
      if (high_held) begin
        high_held = 1'b0;
        if (is_low) begin
          encode_cp(21'h10000 + {1'b0, held_bits, unit.code_unit[9:0]});
          paired = 1'b1;
        end else begin
          encode_cp(21'h00FFFD);
        end
        held_bits = '0;
      end
      if (!paired) begin
        if (is_high) begin
          if (unit.final_unit) begin
            encode_cp(21'h00FFFD);
          end else begin
            high_held = 1'b1;
            held_bits = unit.code_unit[9:0];
          end
        end else if (is_low) begin
          encode_cp(21'h00FFFD);
        end else begin
          encode_cp({5'b0, unit.code_unit});
        end
      end
      if (expected_bytes.size() > start_count) begin
        tail            = expected_bytes[expected_bytes.size() - 1];
        tail.run_last   = 1'b1;
        tail.string_end = unit.final_unit;
        expected_bytes[expected_bytes.size() - 1] = tail;
      end
    endfunction

    function void check_byte(u16u8_pkg::out_item_t got);
      u16u8_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte transaction: utf8_byte %h", got.utf8_byte);
        errors++;
        return;
      end
      want = expected_bytes[0];
      expected_bytes.delete(0);
      if (got.utf8_byte !== want.utf8_byte) begin
        $error("utf8_byte: expected %h, got %h", want.utf8_byte, got.utf8_byte);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, got %b", want.run_last, got.run_last);
        errors++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %b, got %b", want.string_end, got.string_end);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid   = 1'b0;
  u16u8_pkg::in_item_t  in_data    = '0;
  logic                 out_stall  = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  u16u8_pkg::out_item_t out_data;

  int unsigned    idle_pct  = 0;
  int unsigned    stall_pct = 0;
  utf8_scoreboard sb        = new();

  utf16_to_utf8_transcoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_byte(out_data);
      if (in_valid && !in_stall) sb.note_unit(in_data);
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{code_unit: cu, final_unit: fin};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_bmp_3byte();
    logic [15:0] cu;
    if ($urandom_range(1)) cu = 16'($urandom_range(16'h0800, 16'hD7FF));
    else cu = 16'($urandom_range(16'hE000, 16'hFFFF));
    return cu;
  endfunction

  // Mostly well-formed strings with random content; some broken surrogates and raw noise.
  task automatic send_random_strings(input int unsigned unit_goal);
    int unsigned sent;
    int unsigned str_len;
    int unsigned kind;
    logic [15:0] units[$];
    sent = 0;
    while (sent < unit_goal) begin
      units.delete();
      str_len = $urandom_range(1, 8);
      while (units.size() < str_len) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          units.insert(units.size(), 16'($urandom_range(16'h007F)));
        end else if (kind < 45) begin
          units.insert(units.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
        end else if (kind < 65) begin
          units.insert(units.size(), pick_bmp_3byte());
        end else if (kind < 85) begin
          units.insert(units.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
          units.insert(units.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (kind < 90) begin
          units.insert(units.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
        end else if (kind < 95) begin
          units.insert(units.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else begin
          units.insert(units.size(), 16'($urandom));
        end
      end
      foreach (units[i]) send_unit(units[i], i == units.size() - 1);
      sent += units.size();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encoding length boundaries
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFD, 1'b0);
    // lowest and highest supplementary code points
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // held high surrogate followed by a non-low unit
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDC00, 1'b0);
    // lone low, then high surrogate at end of string
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hD800, 1'b1);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b1);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'h0041, 1'b1);

    send_random_strings(50);
    idle_pct  = 68;
    stall_pct = 0;
    send_random_strings(50);
    idle_pct  = 0;
    stall_pct = 68;
    send_random_strings(50);
    idle_pct  = 38;
    stall_pct = 38;
    send_random_strings(50);

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
